>>> src/cfbs_pkg.sv
`default_nettype none
package cfbs_pkg;

  // Stack geometry
  localparam int SLOTS  = 50;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int ADDR_W = $clog2(SLOTS);

  // Field widths
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 8;
  localparam int STATUS_W = 3;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_WORD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SET_TOTAL  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_BLOCK  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_COUNT  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_REFILL     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_SPILL_CNT  = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_SPILL_WORD = 3'd6;

  // Register indexes
  localparam logic REG_FIRST_DATA  = 1'b0;
  localparam logic REG_VOLUME_SIZE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC_RD,
    S_FREE_PUSH,
    S_SPILL_CNT,
    S_SPILL_WORD
  } state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_data_block;
    logic [VALUE_W-1:0] volume_size;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

  function automatic logic [VALUE_W-1:0] inc_sat(input logic [VALUE_W-1:0] v);
    inc_sat = (v == '1) ? v : v + VALUE_W'(1);
  endfunction

  function automatic logic [VALUE_W-1:0] dec_sat(input logic [VALUE_W-1:0] v);
    dec_sat = (v == '0) ? v : v - VALUE_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> src/cfbs_ram.sv
`default_nettype none
module cfbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/cfbs_ctrl.sv
`default_nettype none
module cfbs_ctrl
  import cfbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  // input words
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic [SLOT_W-1:0]   in_slot_index,
  input  wire logic [COUNT_W-1:0]  in_list_count,
  // result words
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [VALUE_W-1:0]       out_block,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [VALUE_W-1:0]       out_free_total,
  output logic                     out_last,
  // stack memory
  output ram_req_t                 ram_req,
  input  wire logic [VALUE_W-1:0]  ram_rdata
);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]  mode_r;
  logic [VALUE_W-1:0] value_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [COUNT_W-1:0] count_r;

  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [VALUE_W-1:0] total_r, total_nxt;
  logic               pending_r, pending_nxt;
  logic [VALUE_W-1:0] pblock_r, pblock_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VALUE_W-1:0]  out_block_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [VALUE_W-1:0]  out_total_r;
  logic                out_last_r;

  logic                emit;
  logic [STATUS_W-1:0] o_status;
  logic [VALUE_W-1:0]  o_block;
  logic [SLOT_W-1:0]   o_slot;
  logic [VALUE_W-1:0]  o_total;
  logic                o_last;

  logic out_free;
  logic pend_hit;
  logic fill_empty;
  logic val_bad;
  logic rd_bad;
  logic spill_last;

  // Shared decode
  assign out_free   = !out_valid_r || out_ready;
  assign pend_hit   = pending_r && (mode_r == MODE_ALLOC || mode_r == MODE_FREE);
  assign fill_empty = (fill_r == '0) || (fill_r > FILL_W'(SLOTS));
  assign val_bad    = (value_r < cfg.first_data_block) || (value_r >= cfg.volume_size);
  assign rd_bad     = (ram_rdata < cfg.first_data_block) || (ram_rdata >= cfg.volume_size);
  assign spill_last = (idx_r == ADDR_W'(SLOTS - 1));

  assign in_tready = (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (pend_hit) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (mode_r == MODE_ALLOC) begin
          if (!fill_empty) state_nxt = S_ALLOC_RD;
          else if (out_free) state_nxt = S_IDLE;
        end else if (mode_r == MODE_FREE) begin
          if (val_bad) begin
            if (out_free) state_nxt = S_IDLE;
          end else if (fill_r >= FILL_W'(SLOTS)) begin
            state_nxt = S_SPILL_CNT;
          end else begin
            state_nxt = S_FREE_PUSH;
          end
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ALLOC_RD: begin
        if (ram_rdata != '0 && rd_bad) state_nxt = S_EXEC;
        else if (out_free) state_nxt = S_IDLE;
      end
      S_FREE_PUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_SPILL_CNT: begin
        if (out_free) state_nxt = S_SPILL_WORD;
      end
      S_SPILL_WORD: begin
        if (out_free && spill_last) state_nxt = S_FREE_PUSH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Results, state updates and memory requests
  always_comb begin
    emit        = 1'b0;
    o_status    = STAT_OK;
    o_block     = '0;
    o_slot      = '0;
    o_last      = 1'b1;
    fill_nxt    = fill_r;
    total_nxt   = total_r;
    pending_nxt = pending_r;
    pblock_nxt  = pblock_r;
    idx_nxt     = idx_r;
    ram_req     = '0;
    case (state_r)
      S_EXEC: begin
        if (pend_hit) begin
          emit     = 1'b1;
          o_status = STAT_REFILL;
          o_block  = pblock_r;
        end else begin
          case (mode_r)
            MODE_ALLOC: begin
              if (fill_empty) begin
                emit     = 1'b1;
                o_status = STAT_NO_SPACE;
                if (out_free) begin
                  fill_nxt  = '0;
                  total_nxt = '0;
                end
              end else begin
                // pop: read the top entry
                fill_nxt      = fill_r - FILL_W'(1);
                ram_req.re    = 1'b1;
                ram_req.raddr = ADDR_W'(fill_r - FILL_W'(1));
              end
            end
            MODE_FREE: begin
              if (val_bad) begin
                emit     = 1'b1;
                o_status = STAT_BAD_BLOCK;
              end else if (fill_r == '0) begin
                // push the zero end marker first
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = '0;
                fill_nxt      = FILL_W'(1);
              end
            end
            MODE_LOAD_WORD: begin
              emit = 1'b1;
              if (pending_r && slot_r < SLOT_W'(SLOTS)) begin
                o_status = STAT_OK;
                if (out_free) begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = slot_r[ADDR_W-1:0];
                  ram_req.wdata = value_r;
                end
              end else begin
                o_status = STAT_BAD_COUNT;
              end
            end
            MODE_LOAD_COUNT: begin
              emit = 1'b1;
              if (!pending_r) begin
                o_status = STAT_BAD_COUNT;
              end else if (!(count_r inside {[1:SLOTS]})) begin
                o_status = STAT_NO_SPACE;
                if (out_free) begin
                  pending_nxt = 1'b0;
                  fill_nxt    = '0;
                  total_nxt   = '0;
                end
              end else begin
                o_status = STAT_OK;
                o_block  = pblock_r;
                if (out_free) begin
                  pending_nxt = 1'b0;
                  fill_nxt    = FILL_W'(count_r);
                  total_nxt   = dec_sat(total_r);
                end
              end
            end
            MODE_SET_TOTAL: begin
              emit = 1'b1;
              if (out_free) total_nxt = value_r;
            end
            default: begin
              emit     = 1'b1;
              o_status = STAT_BAD_COUNT;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        if (ram_rdata == '0) begin
          emit     = 1'b1;
          o_status = STAT_NO_SPACE;
          if (out_free) begin
            fill_nxt  = '0;
            total_nxt = '0;
          end
        end else if (!rd_bad) begin
          emit    = 1'b1;
          o_block = ram_rdata;
          if (fill_r == '0) begin
            // stack drained: ask the host for the next chain block
            o_status = STAT_REFILL;
            if (out_free) begin
              pending_nxt = 1'b1;
              pblock_nxt  = ram_rdata;
            end
          end else begin
            o_status = STAT_OK;
            if (out_free) total_nxt = dec_sat(total_r);
          end
        end
      end
      S_FREE_PUSH: begin
        emit     = 1'b1;
        o_status = STAT_OK;
        o_block  = value_r;
        if (out_free) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = ADDR_W'(fill_r);
          ram_req.wdata = value_r;
          fill_nxt      = fill_r + FILL_W'(1);
          total_nxt     = inc_sat(total_r);
        end
      end
      S_SPILL_CNT: begin
        emit     = 1'b1;
        o_status = STAT_SPILL_CNT;
        o_block  = VALUE_W'(fill_r);
        o_last   = 1'b0;
        if (out_free) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = '0;
          idx_nxt       = '0;
        end
      end
      S_SPILL_WORD: begin
        emit     = 1'b1;
        o_status = STAT_SPILL_WORD;
        o_block  = ram_rdata;
        o_slot   = SLOT_W'(idx_r);
        o_last   = 1'b0;
        if (out_free) begin
          if (spill_last) begin
            fill_nxt = '0;
          end else begin
            idx_nxt       = idx_r + ADDR_W'(1);
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_r + ADDR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    // spill words report the total after the closing push
    if (state_r == S_SPILL_CNT || state_r == S_SPILL_WORD) o_total = inc_sat(total_r);
    else o_total = total_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      pending_r   <= 1'b0;
      pblock_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      total_r   <= total_nxt;
      pending_r <= pending_nxt;
      pblock_r  <= pblock_nxt;
      if (out_free) out_valid_r <= emit;
    end
  end

  // Item capture, spill index and output word
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_tvalid && in_tready) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      slot_r  <= in_slot_index;
      count_r <= in_list_count;
    end
    if (out_free && emit) begin
      out_status_r <= o_status;
      out_block_r  <= o_block;
      out_slot_r   <= o_slot;
      out_total_r  <= o_total;
      out_last_r   <= o_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block      = out_block_r;
  assign out_slot       = out_slot_r;
  assign out_free_total = out_total_r;
  assign out_last       = out_last_r;

  // Reads and writes of the stack never share a cycle, so no forwarding is needed
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("stack read and write in the same cycle");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SLOTS))
    else $error("stack fill above capacity");

  a_pending_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (fill_r == '0))
    else $error("refill pending with a non-empty stack");

  a_spill_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPILL_CNT) |-> (fill_r == FILL_W'(SLOTS)))
    else $error("spill started on a stack that is not full");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r != S_IDLE))
    else $error("non-final word left without a pending item");

endmodule
`default_nettype wire

>>> src/chained_free_block_stack_core.sv
`default_nettype none
// Free-block stack in the classic chained-list style: alloc pops block numbers
// from a stack held in a 50-entry RAM with one write port and one read port,
// free pushes them, and a full stack is spilled as a count word plus one word
// per slot before the push. Each item passes through accept and execute; an
// alloc on a non-empty stack goes on to a read state, and returns to execute
// to pop again for each out-of-range block skipped; a free of an in-range block
// goes on to a push state, also on an empty stack, where the zero end marker is
// written in the execute state; a free onto a full stack first passes through
// the spill states, one result word per spilled entry. Every pop and spilled
// word goes through the registered read of the stack RAM. A result word held
// off by the result side stalls its item until the word is taken. Items are
// taken one at a time; a result waiting in the output register does not hold
// off the next item. Write first_data_block and volume_size only while no item is in flight.
module chained_free_block_stack_core
  import cfbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // value[31:0], slot_index[37:32], list_count[45:38]
  input  wire logic [2:0]  in_tuser,  // mode[2:0]
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata, // block[31:0], slot[37:32], free_total[69:38]
  output logic [2:0]       out_tuser, // status[2:0]
  output logic             out_tlast
);

  cfg_t               cfg_r;
  ram_req_t           ram_req;
  logic [VALUE_W-1:0] ram_rdata;
  logic               cfg_wr;
  logic [SLOT_W-1:0]  o_slot;
  logic [VALUE_W-1:0] o_block;
  logic [VALUE_W-1:0] o_total;

  // Register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FIRST_DATA:  cfg_r.first_data_block <= cfg_pwdata;
        REG_VOLUME_SIZE: cfg_r.volume_size      <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[2])
      REG_FIRST_DATA:  cfg_prdata = cfg_r.first_data_block;
      REG_VOLUME_SIZE: cfg_prdata = cfg_r.volume_size;
      default:         cfg_prdata = '0;
    endcase
  end

  cfbs_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_mode        (in_tuser),
    .in_value       (in_tdata[31:0]),
    .in_slot_index  (in_tdata[37:32]),
    .in_list_count  (in_tdata[45:38]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_tuser),
    .out_block      (o_block),
    .out_slot       (o_slot),
    .out_free_total (o_total),
    .out_last       (out_tlast),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  cfbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Pack the result word
  assign out_tdata = {2'b00, o_total, o_slot, o_block};

endmodule
`default_nettype wire

>>> sim/free_stack_checker.sv
`default_nettype none
// Watches the configuration port and both word channels of the free-block
// stack, keeps its own copy of the stack, the fill, the free total and the
// refill state, and compares every result word with the oldest prediction.
module free_stack_checker
  import cfbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,  // value[31:0], slot_index[37:32], list_count[45:38]
  input  wire logic [2:0]  in_tuser,  // mode[2:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata, // block[31:0], slot[37:32], free_total[69:38]
  input  wire logic [2:0]  out_tuser, // status[2:0]
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               results_due,
  output logic             refill_wanted
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  block;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  total;
    logic                last;
  } stack_result_t;

  stack_result_t      due_results[$];
  stack_result_t      step_results[$];
  stack_result_t      seen;
  stack_result_t      wanted;
  logic [VALUE_W-1:0] free_list [SLOTS];
  int unsigned        fill_level;
  logic [VALUE_W-1:0] free_count;
  logic [VALUE_W-1:0] lowest_block;
  logic [VALUE_W-1:0] block_limit;
  logic [VALUE_W-1:0] refill_block;
  logic               refill_open;

  function automatic bit outside_volume(input logic [VALUE_W-1:0] b);
    return (b < lowest_block) || (b >= block_limit);
  endfunction

  function automatic void note(input logic [STATUS_W-1:0] s, input logic [VALUE_W-1:0] b,
                               input logic [SLOT_W-1:0] sl);
    stack_result_t r;
    r.status = s;
    r.block  = b;
    r.slot   = sl;
    r.total  = '0;
    r.last   = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void run_dry();
    fill_level = 0;
    free_count = '0;
  endfunction

  // Pop until an in-range block turns up; a zero or an empty stack means no space
  function automatic void alloc_block();
    logic [VALUE_W-1:0] b;
    bit                 found;
    found = 1'b0;
    b = '0;
    while (!found) begin
      if (fill_level == 0) begin
        run_dry();
        note(STAT_NO_SPACE, '0, '0);
        return;
      end
      fill_level--;
      b = free_list[fill_level];
      if (b == '0) begin
        run_dry();
        note(STAT_NO_SPACE, '0, '0);
        return;
      end
      found = !outside_volume(b);
    end
    if (fill_level == 0) begin
      refill_open  = 1'b1;
      refill_block = b;
      note(STAT_REFILL, b, '0);
    end else begin
      if (free_count != '0) free_count--;
      note(STAT_OK, b, '0);
    end
  endfunction

  // Push a freed block, spilling count and every slot first when the stack is full
  function automatic void free_block(input logic [VALUE_W-1:0] b);
    if (outside_volume(b)) begin
      note(STAT_BAD_BLOCK, '0, '0);
      return;
    end
    if (fill_level == 0) begin
      free_list[0] = '0;
      fill_level = 1;
    end
    if (fill_level >= SLOTS) begin
      note(STAT_SPILL_CNT, VALUE_W'(fill_level), '0);
      for (int i = 0; i < SLOTS; i++) note(STAT_SPILL_WORD, free_list[i], SLOT_W'(i));
      fill_level = 0;
    end
    free_list[fill_level] = b;
    fill_level++;
    if (free_count != '1) free_count++;
    note(STAT_OK, b, '0);
  endfunction

  function automatic void apply_stack_op(input logic [MODE_W-1:0] mode,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [COUNT_W-1:0] count);
    step_results.delete();
    if ((mode == MODE_ALLOC || mode == MODE_FREE) && refill_open) begin
      note(STAT_REFILL, refill_block, '0);
    end else begin
      case (mode)
        MODE_ALLOC: alloc_block();
        MODE_FREE: free_block(value);
        MODE_LOAD_WORD: begin
          if (refill_open && slot < SLOTS) begin
            free_list[slot] = value;
            note(STAT_OK, '0, '0);
          end else begin
            note(STAT_BAD_COUNT, '0, '0);
          end
        end
        MODE_LOAD_COUNT: begin
          if (!refill_open) begin
            note(STAT_BAD_COUNT, '0, '0);
          end else begin
            refill_open = 1'b0;
            if (count == '0 || count > SLOTS) begin
              run_dry();
              note(STAT_NO_SPACE, '0, '0);
            end else begin
              fill_level = 32'(count);
              if (free_count != '0) free_count--;
              note(STAT_OK, refill_block, '0);
            end
          end
        end
        MODE_SET_TOTAL: begin
          free_count = value;
          note(STAT_OK, '0, '0);
        end
        default: note(STAT_BAD_COUNT, '0, '0);
      endcase
    end
    // Every result carries the total after the whole step; flag the final one
    foreach (step_results[k]) begin
      step_results[k].total = free_count;
      step_results[k].last  = (k == step_results.size() - 1);
      due_results.push_back(step_results[k]);
    end
  endfunction

  function automatic string show(input stack_result_t r);
    return $sformatf("status=%0d block=%h slot=%0d free_total=%h last=%b",
                     r.status, r.block, r.slot, r.total, r.last);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      for (int i = 0; i < SLOTS; i++) free_list[i] = '0;
      fill_level   = 0;
      free_count   = '0;
      lowest_block = '0;
      block_limit  = '0;
      refill_block = '0;
      refill_open  = 1'b0;
      fail_count   = 0;
    end else begin
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_FIRST_DATA:  lowest_block = cfg_pwdata;
          REG_VOLUME_SIZE: block_limit  = cfg_pwdata;
          default: ;
        endcase
      end
      // Compare each result word with the oldest prediction
      if (out_tvalid && out_tready) begin
        seen.status = out_tuser;
        seen.block  = out_tdata[31:0];
        seen.slot   = out_tdata[37:32];
        seen.total  = out_tdata[69:38];
        seen.last   = out_tlast;
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word with nothing expected: got %s", $realtime, show(seen));
        end else begin
          wanted = due_results.pop_front();
          if (seen !== wanted) begin
            fail_count++;
            $display("%0t: result word differs: expected %s, got %s", $realtime,
                     show(wanted), show(seen));
          end
        end
      end
      // Predict the results of each accepted input word
      if (in_tvalid && in_tready)
        apply_stack_op(in_tuser, in_tdata[31:0], in_tdata[37:32], in_tdata[45:38]);
    end
    results_due   = due_results.size();
    refill_wanted = refill_open;
  end

endmodule
`default_nettype wire

>>> sim/tb_chained_free_block_stack_core.sv
`default_nettype none
module tb_chained_free_block_stack_core
  import cfbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;  // value[31:0], slot_index[37:32], list_count[45:38]
  logic [2:0]  in_tuser = '0;  // mode[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;      // block[31:0], slot[37:32], free_total[69:38]
  logic [2:0]  out_tuser;      // status[2:0]
  logic        out_tlast;

  int          fail_count;
  int          results_due;
  logic        refill_wanted;

  logic [VALUE_W-1:0] vol_lo = '0;
  logic [VALUE_W-1:0] vol_hi = '0;
  int          words_sent = 0;
  int          send_calm = 0;
  int          calm_left = 0;
  int          stall_left = 0;
  int          ready_roll;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  chained_free_block_stack_core dut (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  free_stack_checker u_checker (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .results_due, .refill_wanted
  );

  // Stall the result side: short stalls, a few long ones, and calm stretches
  always @(negedge clk) begin
    if (calm_left != 0) begin
      out_tready <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      ready_roll = $urandom_range(99, 0);
      out_tready <= (ready_roll >= 30);
      if (ready_roll < 6) calm_left <= $urandom_range(60, 20);
      else if (ready_roll < 10) stall_left <= $urandom_range(40, 10);
      else if (ready_roll < 30) stall_left <= $urandom_range(3, 0);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int next_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (send_calm != 0) begin
      send_calm--;
      return 0;
    end
    if (r < 8) send_calm = $urandom_range(40, 10);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Mostly blocks inside the volume, with zeros, boundaries and wild values
  function automatic logic [VALUE_W-1:0] pick_block();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75 && vol_hi > vol_lo) return $urandom_range(vol_hi - 1, vol_lo);
    if (r < 82) return '0;
    if (r < 90) return r[0] ? vol_lo - 1 : vol_hi;
    return $urandom;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_word(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                            input logic [SLOT_W-1:0] slot, input logic [COUNT_W-1:0] count);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, count, slot, value};
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Hold off input until every predicted result has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_volume(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi);
    vol_lo = lo;
    vol_hi = hi;
    write_reg(REG_FIRST_DATA, lo);
    @(negedge clk);
    write_reg(REG_VOLUME_SIZE, hi);
    @(negedge clk);
  endtask

  task automatic directed_words();
    // Empty stack, loads out of state, undefined modes
    offer_word(MODE_ALLOC, '0, '0, '0);
    offer_word(MODE_LOAD_WORD, '1, SLOT_W'(SLOTS - 1), '0);
    offer_word(MODE_LOAD_COUNT, '0, '0, '1);
    for (int m = 1; m <= 3; m++)
      offer_word(MODE_W'(MODE_SET_TOTAL + m), $urandom, '1, '1);
    // Saturated total, boundary frees, zero end marker
    offer_word(MODE_SET_TOTAL, '1, '0, '0);
    offer_word(MODE_FREE, vol_lo - 1, '0, '0);
    offer_word(MODE_FREE, vol_hi, '0, '0);
    offer_word(MODE_FREE, vol_lo, '0, '0);
    offer_word(MODE_FREE, vol_hi - 1, '0, '0);
    repeat (3) offer_word(MODE_ALLOC, '0, '0, '0);
    // Fill every slot; the last of these frees finds the stack full and spills it
    repeat (SLOTS) offer_word(MODE_FREE, $urandom_range(vol_hi - 1, vol_lo), '0, '0);
    // Emptying pop asks for a refill; alloc and free wait on it
    offer_word(MODE_ALLOC, '0, '0, '0);
    offer_word(MODE_ALLOC, '0, '0, '0);
    offer_word(MODE_FREE, vol_lo + 4, '0, '0);
    offer_word(MODE_LOAD_WORD, $urandom, SLOT_W'(SLOTS), '0);
    offer_word(MODE_LOAD_WORD, vol_lo + 84, '0, '0);
    offer_word(MODE_LOAD_COUNT, '0, '0, 8'd1);
    offer_word(MODE_ALLOC, '0, '0, '0);
    offer_word(MODE_LOAD_COUNT, '0, '0, COUNT_W'(SLOTS + 1));
  endtask

  task automatic refill_sequence();
    int unsigned r;
    repeat ($urandom_range(4, 0)) begin
      r = $urandom_range(9, 0);
      offer_word(MODE_LOAD_WORD, pick_block(),
                 (r == 0) ? SLOT_W'($urandom_range(63, SLOTS)) :
                            SLOT_W'($urandom_range(SLOTS - 1, 0)),
                 COUNT_W'($urandom));
    end
    r = $urandom_range(99, 0);
    if (r < 80)
      offer_word(MODE_LOAD_COUNT, $urandom, SLOT_W'($urandom),
                 COUNT_W'($urandom_range(SLOTS, 1)));
    else if (r < 90)
      offer_word(MODE_LOAD_COUNT, $urandom, SLOT_W'($urandom), '0);
    else
      offer_word(MODE_LOAD_COUNT, $urandom, SLOT_W'($urandom),
                 COUNT_W'($urandom_range(255, SLOTS + 1)));
  endtask

  task automatic random_words(input int target);
    int unsigned r;
    logic [VALUE_W-1:0] total;
    target += words_sent;
    while (words_sent < target) begin
      r = $urandom_range(99, 0);
      if (refill_wanted && r < 85) begin
        refill_sequence();
      end else if (r < 30) begin
        repeat ($urandom_range(6, 1))
          offer_word(MODE_FREE, pick_block(), SLOT_W'($urandom), COUNT_W'($urandom));
      end else if (r < 55) begin
        repeat ($urandom_range(6, 1))
          offer_word(MODE_ALLOC, $urandom, SLOT_W'($urandom), COUNT_W'($urandom));
      end else if (r < 62) begin
        repeat ($urandom_range(55, 20)) offer_word(MODE_FREE, pick_block(), '0, '0);
      end else if (r < 67) begin
        case ($urandom_range(4, 0))
          0: total = '1;
          1: total = '1 - 1;
          2: total = '0;
          3: total = 1;
          default: total = $urandom;
        endcase
        offer_word(MODE_SET_TOTAL, total, SLOT_W'($urandom), COUNT_W'($urandom));
      end else if (r < 80) begin
        offer_word(MODE_W'($urandom_range(7, 0)), $urandom, SLOT_W'($urandom_range(63, 0)),
                   COUNT_W'($urandom));
      end else if (r < 83) begin
        drain_results();
      end else begin
        repeat ($urandom_range(30, 10)) offer_word(MODE_ALLOC, '0, '0, '0);
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    set_volume(32'd16, 32'd4096);
    directed_words();
    random_words(130);
    drain_results();

    // Every block but the all-ones value valid
    set_volume('0, '1);
    random_words(100);
    drain_results();

    // Nothing valid
    set_volume('1, '0);
    random_words(40);
    drain_results();

    // A single valid block
    set_volume(32'd100, 32'd101);
    random_words(60);
    drain_results();

    set_volume(32'd16, 32'd4096);
    random_words(40);
    drain_results();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
